[rtl/ukrts_pkg.sv]
// Shared types, sizes and codes for the keyed record table with chained cells.
package ukrts_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int PAY_W = 64;
    localparam int CMD_W = 2;
    localparam int STAT_W = 2;
    localparam int IN_DATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_W + PAY_W + CNT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] MODE_HOLD       = 2'd0;
    localparam logic [1:0] MODE_TAKE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_TAKE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_LOAD       = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        logic [1:0] mode;
        rec_t       load_rec;
    } cell_ctrl_t;

endpackage

[rtl/ukrts_cell.sv]
// One table cell: holds a record, trades it with a neighbor, compares keys.
module ukrts_cell
    import ukrts_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  rec_t       left_rec,
    input  rec_t       right_rec,
    output rec_t       rec,
    output logic       gt_right
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        case (ctrl.mode)
            MODE_HOLD:       rec_next = rec_reg;
            MODE_TAKE_RIGHT: rec_next = right_rec;
            MODE_TAKE_LEFT:  rec_next = left_rec;
            MODE_LOAD:       rec_next = ctrl.load_rec;
            default:         rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;
    // Signed key order against the right-hand neighbor.
    assign gt_right = $signed(rec_reg.key) > $signed(right_rec.key);

endmodule

[rtl/unique_key_record_table_sort.sv]
// Top level of the keyed record table: command handshake, sequencer and cell row.
//
// Input items arrive on the s_axis channel. s_axis_tuser carries the command
// (0 add, 1 sort, 2 list); s_axis_tdata carries the key and the payload word.
// Result items leave on the m_axis channel with the status in m_axis_tuser and
// the listed record plus the entry count in m_axis_tdata; m_axis_tlast marks
// the final result item of a command.
// The table is a row of TABLE_ENTRIES cells. Add rotates the whole row once
// past the head cell to look for the key, then appends. Sort runs
// TABLE_ENTRIES odd-even exchange phases between neighboring cells. List
// rotates the row once and emits the head record for each stored entry, one
// result item per cycle while the receiver keeps up. An unused command, and a
// list of an empty table, answer straight from the idle state.
// One command is worked on at a time; the next item is taken once the current
// one is finished and the output register is free or being drained.
// Reset empties the table (the count goes to zero) and drops any pending result.
// When the receiver stalls, the result item holds in the output register and
// the row stops rotating until it is taken, so nothing is lost.
module unique_key_record_table_sort
    import ukrts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // record_key, record_payload
    input  logic [CMD_W-1:0]      s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_key, out_payload, entry_total, zero fill
    output logic [STAT_W-1:0]     m_axis_tuser,   // status
    output logic                  m_axis_tlast
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_ADD_FIN  = 3'd2;
    localparam logic [2:0] S_SORT     = 3'd3;
    localparam logic [2:0] S_SORT_FIN = 3'd4;
    localparam logic [2:0] S_LIST     = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] rot_reg, rot_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic [KEY_W-1:0] key_hold_reg, key_hold_next;
    logic [PAY_W-1:0] pay_hold_reg, pay_hold_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [PAY_W-1:0]  out_pay_reg, out_pay_next;
    logic [CNT_W-1:0]  out_total_reg, out_total_next;
    logic              out_last_reg, out_last_next;

    logic in_accept, out_free, out_load;
    logic rotate, sort_en, load_en;
    logic rot_last, head_in_use;
    logic [IDX_W-1:0] rot_inc;

    rec_t       rec [TABLE_ENTRIES];
    logic       gt [TABLE_ENTRIES];
    logic       swap [TABLE_ENTRIES];
    logic       swap_left [TABLE_ENTRIES];
    cell_ctrl_t ctrl [TABLE_ENTRIES];

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;

    assign rot_last    = rot_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign rot_inc     = rot_last ? '0 : rot_reg + IDX_W'(1);
    // The head cell holds the entry whose original place equals the rotation count.
    assign head_in_use = CNT_W'(rot_reg) < count_reg;

    always_comb
    begin
        state_next      = state_reg;
        rot_next        = rot_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        key_hold_next   = key_hold_reg;
        pay_hold_next   = pay_hold_reg;
        rotate          = 1'b0;
        sort_en         = 1'b0;
        load_en         = 1'b0;
        out_load        = 1'b0;
        out_status_next = ST_OK;
        out_key_next    = '0;
        out_pay_next    = '0;
        out_total_next  = count_reg;
        out_last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    rot_next = '0;
                    case (s_axis_tuser)
                        CMD_ADD:
                        begin
                            key_hold_next = s_axis_tdata[KEY_W-1:0];
                            pay_hold_next = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
                            found_next    = 1'b0;
                            state_next    = S_ADD;
                        end
                        CMD_SORT:
                        begin
                            state_next = S_SORT;
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                rotate   = 1'b1;
                rot_next = rot_inc;
                if (head_in_use && (rec[0].key == key_hold_reg))
                begin
                    found_next = 1'b1;
                end
                if (rot_last)
                begin
                    state_next = S_ADD_FIN;
                end
            end
            S_ADD_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (found_reg)
                    begin
                        out_status_next = ST_DUP;
                    end
                    else if (count_reg >= CNT_W'(TABLE_ENTRIES))
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        load_en        = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        out_total_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_SORT:
            begin
                sort_en  = 1'b1;
                rot_next = rot_inc;
                if (rot_last)
                begin
                    state_next = S_SORT_FIN;
                end
            end
            S_SORT_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (!head_in_use || out_free)
                begin
                    rotate   = 1'b1;
                    rot_next = rot_inc;
                    if (rot_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (head_in_use && out_free)
                begin
                    out_load      = 1'b1;
                    out_key_next  = rec[0].key;
                    out_pay_next  = rec[0].payload;
                    out_last_next = (CNT_W'(rot_reg) + CNT_W'(1)) == count_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
            count_reg <= count_next;
            found_reg <= found_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_hold_reg <= key_hold_next;
        pay_hold_reg <= pay_hold_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_pay_reg    <= out_pay_next;
            out_total_reg  <= out_total_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Cell row. Rotation moves every record one place toward the head, with
    // the head wrapping round to the tail. Sorting exchanges neighbor pairs,
    // starting at even cells in even phases and odd cells in odd phases;
    // cells past the stored count never take part.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        if (i < TABLE_ENTRIES - 1)
        begin : g_pair
            assign swap[i] = sort_en && (rot_reg[0] == 1'(i % 2))
                             && (CNT_W'(i + 1) < count_reg) && gt[i];
        end
        else
        begin : g_tail
            assign swap[i] = 1'b0;
        end

        if (i > 0)
        begin : g_left
            assign swap_left[i] = swap[i-1];
        end
        else
        begin : g_head
            assign swap_left[i] = 1'b0;
        end

        always_comb
        begin
            ctrl[i].load_rec = {key_hold_reg, pay_hold_reg};
            ctrl[i].mode     = MODE_HOLD;
            if (rotate)
            begin
                ctrl[i].mode = MODE_TAKE_RIGHT;
            end
            else if (swap[i])
            begin
                ctrl[i].mode = MODE_TAKE_RIGHT;
            end
            else if (swap_left[i])
            begin
                ctrl[i].mode = MODE_TAKE_LEFT;
            end
            else if (load_en && (count_reg == CNT_W'(i)))
            begin
                ctrl[i].mode = MODE_LOAD;
            end
        end

        ukrts_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .left_rec  (rec[(i + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
            .right_rec (rec[(i + 1) % TABLE_ENTRIES]),
            .rec       (rec[i]),
            .gt_right  (gt[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - KEY_W - PAY_W - CNT_W){1'b0}},
                            out_total_reg, out_pay_reg, out_key_reg};

endmodule

[test/unique_key_record_table_sort_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the keyed record table: directed rows, then random traffic.
module unique_key_record_table_sort_tb
    import ukrts_pkg::*;
();

    // Command code that the block has no use for; it must answer with a plain ok item.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int DIR_ROWS       = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int REPORT_MAX     = 10;

    // One result item as the block should send it.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [CNT_W-1:0]  total;
        logic              last;
    } table_result_t;

    // One row of the directed stimulus. Where typed is set, the single result item
    // is given here by hand (always with zero key and payload and last set).
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  total;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // record_key, record_payload
    logic [CMD_W-1:0]      s_axis_tuser;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // out_key, out_payload, entry_total, zero fill
    logic [STAT_W-1:0]     m_axis_tuser;   // status
    logic                  m_axis_tlast;

    // Predicted contents of the table.
    logic [KEY_W-1:0] key_tbl [TABLE_ENTRIES];
    logic [PAY_W-1:0] payload_tbl [TABLE_ENTRIES];
    int               rec_count;

    // Result items predicted but not yet seen, oldest first.
    table_result_t pending_results [$];

    dir_row_t dir_rows [DIR_ROWS];

    int mismatch_count;
    int idle_cycles;
    int rx_hold;
    bit steady;          // when set, neither side inserts gaps

    unique_key_record_table_sort u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Gap length in cycles: mostly short, now and then long.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic void push_result(logic [STAT_W-1:0] st, logic [KEY_W-1:0] key,
                                        logic [PAY_W-1:0] pay, logic last);
        table_result_t r;
        r.status  = st;
        r.key     = key;
        r.payload = pay;
        r.total   = CNT_W'(rec_count);
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Updates the predicted table for one accepted command and queues its result items.
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [PAY_W-1:0] pay);
        int               i;
        int               j;
        bit               found;
        logic [KEY_W-1:0] hold_key;
        logic [PAY_W-1:0] hold_pay;
        case (cmd)
            CMD_ADD:
            begin
                // The duplicate search wins over the full check.
                found = 1'b0;
                for (i = 0; i < rec_count; i++)
                    if (key_tbl[i] == key)
                        found = 1'b1;
                if (found)
                    push_result(ST_DUP, '0, '0, 1'b1);
                else if (rec_count >= TABLE_ENTRIES)
                    push_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    key_tbl[rec_count]     = key;
                    payload_tbl[rec_count] = pay;
                    rec_count++;
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_SORT:
            begin
                // Keys are unique, so any correct sort gives the same order.
                for (i = 1; i < rec_count; i++)
                begin
                    hold_key = key_tbl[i];
                    hold_pay = payload_tbl[i];
                    j = i;
                    while (j > 0 && $signed(key_tbl[j-1]) > $signed(hold_key))
                    begin
                        key_tbl[j]     = key_tbl[j-1];
                        payload_tbl[j] = payload_tbl[j-1];
                        j--;
                    end
                    key_tbl[j]     = hold_key;
                    payload_tbl[j] = hold_pay;
                end
                push_result(ST_OK, '0, '0, 1'b1);
            end
            CMD_LIST:
            begin
                if (rec_count == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (i = 0; i < rec_count; i++)
                        push_result(ST_OK, key_tbl[i], payload_tbl[i], i == rec_count - 1);
            end
            default:
                push_result(ST_OK, '0, '0, 1'b1);
        endcase
    endtask

    // Presents one item, at times after a random gap, and waits until it is taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 40)
            gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {pay, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_command(cmd, key, pay);
    endtask

    // Holds the sender back until every predicted result item has come.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(int add_pct, int sort_pct, int list_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return CMD_ADD;
        if (r < add_pct + sort_pct)
            return CMD_SORT;
        if (r < add_pct + sort_pct + list_pct)
            return CMD_LIST;
        return CMD_UNUSED;
    endfunction

    // Keys: some repeat a stored key, some are extremes, many are small signed
    // values so that sorting mixes signs, the rest are fully random.
    function automatic logic [KEY_W-1:0] pick_key(int dup_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < dup_pct && rec_count > 0)
            return key_tbl[$urandom_range(0, rec_count - 1)];
        if (r < dup_pct + 8)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < dup_pct + 40)
            return KEY_W'($signed($urandom_range(0, 400)) - 200);
        return $urandom;
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '1;
        if (r < 16)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Receiver: tready drops for random stretches unless the run is in a steady part.
    initial
    begin
        m_axis_tready = 1'b0;
        rx_hold = 0;
    end

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                rx_hold = gap_len();
        end
    end

    // Checker: every accepted result item is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        table_result_t got;
        logic          pad_bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status  = m_axis_tuser;
            got.key     = m_axis_tdata[KEY_W-1:0];
            got.payload = m_axis_tdata[KEY_W+PAY_W-1:KEY_W];
            got.total   = m_axis_tdata[KEY_W+PAY_W+CNT_W-1:KEY_W+PAY_W];
            got.last    = m_axis_tlast;
            pad_bad     = |m_axis_tdata[OUT_DATA_W-1:KEY_W+PAY_W+CNT_W];
            if (pending_results.size() == 0)
                note_failure($sformatf({"unexpected result item: st=%0d key=%h pay=%h ",
                                        "tot=%0d last=%0b"},
                                       got.status, got.key, got.payload, got.total,
                                       got.last));
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.key != want.key ||
                    got.payload != want.payload || got.total != want.total ||
                    got.last != want.last || pad_bad)
                    note_failure($sformatf({"result mismatch: expected st=%0d key=%h pay=%h ",
                                            "tot=%0d last=%0b, got st=%0d key=%h pay=%h ",
                                            "tot=%0d last=%0b pad=%0b"},
                                           want.status, want.key, want.payload, want.total,
                                           want.last, got.status, got.key, got.payload,
                                           got.total, got.last, pad_bad));
            end
        end
    end

    // Watchdog: too long without any item moving on either side means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d result items outstanding",
                     pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        logic [CMD_W-1:0] cmd;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_ADD;
        steady         = 1'b0;
        rec_count      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;

        // Directed rows. An empty table first, then both key extremes, zero and
        // minus one, duplicates of stored keys, and sorts checked by the lists after them.
        dir_rows[0]  = '{CMD_LIST,   32'h0000_0000, 64'h0,                  1'b1, ST_EMPTY, 7'd0};
        dir_rows[1]  = '{CMD_SORT,   32'h0000_0000, 64'h0,                  1'b1, ST_OK,    7'd0};
        dir_rows[2]  = '{CMD_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,    7'd0};
        dir_rows[3]  = '{CMD_ADD,    32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,    7'd1};
        dir_rows[4]  = '{CMD_ADD,    32'h8000_0000, 64'h0,                  1'b1, ST_OK,    7'd2};
        dir_rows[5]  = '{CMD_ADD,    32'h0000_0000, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK,    7'd3};
        dir_rows[6]  = '{CMD_ADD,    32'hFFFF_FFFF, 64'h8000_0000_0000_0001, 1'b1, ST_OK,    7'd4};
        dir_rows[7]  = '{CMD_ADD,    32'h0000_0001, 64'h5555_AAAA_5555_AAAA, 1'b1, ST_OK,    7'd5};
        dir_rows[8]  = '{CMD_ADD,    32'h7FFF_FFFF, 64'h1,                  1'b1, ST_DUP,   7'd5};
        dir_rows[9]  = '{CMD_ADD,    32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_DUP,   7'd5};
        dir_rows[10] = '{CMD_LIST,   32'h0000_0000, 64'h0,                  1'b0, ST_OK,    7'd0};
        dir_rows[11] = '{CMD_SORT,   32'h0000_0000, 64'h0,                  1'b1, ST_OK,    7'd5};
        dir_rows[12] = '{CMD_LIST,   32'h0000_0000, 64'h0,                  1'b0, ST_OK,    7'd0};
        dir_rows[13] = '{CMD_UNUSED, 32'h1234_5678, 64'hDEAD_BEEF_0000_0000, 1'b1, ST_OK,    7'd5};
        dir_rows[14] = '{CMD_ADD,    32'h8000_0001, 64'hAAAA_5555_AAAA_5555, 1'b1, ST_OK,    7'd6};
        dir_rows[15] = '{CMD_ADD,    32'h7FFF_FFFE, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1, ST_OK,    7'd7};
        dir_rows[16] = '{CMD_LIST,   32'h0000_0000, 64'h0,                  1'b0, ST_OK,    7'd0};
        dir_rows[17] = '{CMD_SORT,   32'h0000_0000, 64'h0,                  1'b1, ST_OK,    7'd7};
        dir_rows[18] = '{CMD_LIST,   32'h0000_0000, 64'h0,                  1'b0, ST_OK,    7'd0};
        dir_rows[19] = '{CMD_ADD,    32'h0000_0000, 64'h0,                  1'b1, ST_DUP,   7'd7};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].payload);
            if (dir_rows[i].typed)
            begin
                // Keep the table state from the predictor but check the hand-written item.
                void'(pending_results.pop_back());
                pending_results.push_back('{dir_rows[i].status, '0, '0,
                                            dir_rows[i].total, 1'b1});
            end
        end
        drain_results();

        // Random mix while the table grows; now and then the sender waits for
        // the block to empty its output entirely.
        for (i = 0; i < 120; i++)
        begin
            cmd = pick_command(55, 15, 20);
            send_item(cmd, pick_key(15), pick_payload());
            if ($urandom_range(0, 99) < 5)
                drain_results();
        end
        drain_results();

        // Fill the table to the top with no idling on either side.
        steady = 1'b1;
        while (rec_count < TABLE_ENTRIES)
            send_item(CMD_ADD, pick_key(0), pick_payload());

        // Full table: duplicates and overflows, sorts and long lists.
        for (i = 0; i < 100; i++)
        begin
            if (i == 30)
                steady = 1'b0;
            cmd = pick_command(50, 20, 20);
            send_item(cmd, pick_key(50), pick_payload());
        end
        drain_results();

        // Let the block settle so that a stray extra item would still be seen.
        repeat (TAIL_CYCLES) @(posedge clk);

        n = pending_results.size();
        if (n != 0)
            note_failure($sformatf("%0d result items never arrived", n));

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/ukrts_pkg.sv
rtl/ukrts_cell.sv
rtl/unique_key_record_table_sort.sv
test/unique_key_record_table_sort_tb.sv
